FILE: rtl/html_char_reference_decoder_unit_macros.svh
// Assertion macros for the character reference decoder.
// Used by the controller and top level.
`ifndef HTML_CHAR_REFERENCE_DECODER_UNIT_MACROS_SVH
`define HTML_CHAR_REFERENCE_DECODER_UNIT_MACROS_SVH
// implication checked on every clock edge out of reset
`define HCRD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// next-cycle implication
`define HCRD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

FILE: rtl/hcrd_pkg.sv
// Shared types and constants for the character reference decoder.
// No dependencies.
`default_nettype none
package hcrd_pkg;
	localparam logic [7:0] CH_HASH = 8'h23;
	localparam logic [7:0] CH_LX = 8'h78;
	localparam logic [7:0] CH_UX = 8'h58;
	localparam logic [20:0] CP_MAX = 21'h10FFFF;
	localparam int ROM_NAME_MAX = 8;
	localparam int ROM_COUNT = 246;
	localparam int ROM_AW = 8;

	typedef enum logic [2:0] {
		PH_LEAD, PH_FIRST, PH_HASH, PH_DEC, PH_HEX, PH_NAME
	} phase_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       final_req;
	} in_item_t;

	typedef struct packed {
		logic [7:0]  utf8_byte;
		logic [20:0] code_point;
		logic        ok;
		logic        end_of_run;
	} out_item_t;

	// controller -> datapath
	typedef struct packed {
		logic       step;      // absorb a non-final byte
		logic       clear;     // clear per-entity state
		logic       rom_start; // begin name search
		logic       rom_next;  // advance search
		logic       load_out;  // register verdict into output encoder
		logic       good;      // verdict to load
		logic [1:0] byte_idx;  // which output byte
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		phase_t     phase;
		logic       num_good;
		logic       name_ok;   // name state allows lookup
		logic       hit;       // current ROM entry matches
		logic       rom_last;  // current entry is last
		logic [2:0] nbytes;    // UTF-8 length of chosen cp
	} dp_sts_t;

	typedef struct packed {
		logic [63:0] nm;  // first char in bits [7:0]
		logic [3:0]  len;
		logic [20:0] cp;
	} rom_entry_t;

	function automatic rom_entry_t rom_e(input string s, input int cp);
		rom_entry_t e;
		e.nm = '0;
		e.len = 4'(s.len());
		for (int k = 0; k < ROM_NAME_MAX; k++)
			if (k < s.len()) e.nm[k*8 +: 8] = s[k];
		e.cp = 21'(cp);
		return e;
	endfunction

	function automatic rom_entry_t name_rom(input logic [ROM_AW-1:0] i);
		rom_entry_t e;
		e = '0;
		case (i)
			0: e = rom_e("quot",34); 1: e = rom_e("QUOT",34); 2: e = rom_e("apos",39);
			3: e = rom_e("APOS",39); 4: e = rom_e("amp",38); 5: e = rom_e("AMP",38);
			6: e = rom_e("lt",60); 7: e = rom_e("LT",60); 8: e = rom_e("gt",62);
			9: e = rom_e("GT",62); 10: e = rom_e("nbsp",160); 11: e = rom_e("iexcl",161);
			12: e = rom_e("cent",162); 13: e = rom_e("pound",163);
			14: e = rom_e("curren",164); 15: e = rom_e("yen",165);
			16: e = rom_e("brvbar",166); 17: e = rom_e("sect",167);
			18: e = rom_e("uml",168); 19: e = rom_e("copy",169); 20: e = rom_e("ordf",170);
			21: e = rom_e("laquo",171); 22: e = rom_e("not",172); 23: e = rom_e("shy",173);
			24: e = rom_e("reg",174); 25: e = rom_e("macr",175); 26: e = rom_e("deg",176);
			27: e = rom_e("plusmn",177); 28: e = rom_e("sup2",178);
			29: e = rom_e("sup3",179); 30: e = rom_e("acute",180);
			31: e = rom_e("micro",181); 32: e = rom_e("para",182);
			33: e = rom_e("middot",183); 34: e = rom_e("cedil",184);
			35: e = rom_e("sup1",185); 36: e = rom_e("ordm",186);
			37: e = rom_e("raquo",187); 38: e = rom_e("frac14",188);
			39: e = rom_e("frac12",189); 40: e = rom_e("frac34",190);
			41: e = rom_e("iquest",191); 42: e = rom_e("times",215);
			43: e = rom_e("divide",247); 44: e = rom_e("Agrave",192);
			45: e = rom_e("Aacute",193); 46: e = rom_e("Acirc",194);
			47: e = rom_e("Atilde",195); 48: e = rom_e("Auml",196);
			49: e = rom_e("Aring",197); 50: e = rom_e("AElig",198);
			51: e = rom_e("Ccedil",199); 52: e = rom_e("Egrave",200);
			53: e = rom_e("Eacute",201); 54: e = rom_e("Ecirc",202);
			55: e = rom_e("Euml",203); 56: e = rom_e("Igrave",204);
			57: e = rom_e("Iacute",205); 58: e = rom_e("Icirc",206);
			59: e = rom_e("Iuml",207); 60: e = rom_e("ETH",208);
			61: e = rom_e("Ntilde",209); 62: e = rom_e("Ograve",210);
			63: e = rom_e("Oacute",211); 64: e = rom_e("Ocirc",212);
			65: e = rom_e("Otilde",213); 66: e = rom_e("Ouml",214);
			67: e = rom_e("Oslash",216); 68: e = rom_e("Ugrave",217);
			69: e = rom_e("Uacute",218); 70: e = rom_e("Ucirc",219);
			71: e = rom_e("Uuml",220); 72: e = rom_e("Yacute",221);
			73: e = rom_e("THORN",222); 74: e = rom_e("szlig",223);
			75: e = rom_e("agrave",224); 76: e = rom_e("aacute",225);
			77: e = rom_e("acirc",226); 78: e = rom_e("atilde",227);
			79: e = rom_e("auml",228); 80: e = rom_e("aring",229);
			81: e = rom_e("aelig",230); 82: e = rom_e("ccedil",231);
			83: e = rom_e("egrave",232); 84: e = rom_e("eacute",233);
			85: e = rom_e("ecirc",234); 86: e = rom_e("euml",235);
			87: e = rom_e("igrave",236); 88: e = rom_e("iacute",237);
			89: e = rom_e("icirc",238); 90: e = rom_e("iuml",239);
			91: e = rom_e("eth",240); 92: e = rom_e("ntilde",241);
			93: e = rom_e("ograve",242); 94: e = rom_e("oacute",243);
			95: e = rom_e("ocirc",244); 96: e = rom_e("otilde",245);
			97: e = rom_e("ouml",246); 98: e = rom_e("oslash",248);
			99: e = rom_e("ugrave",249); 100: e = rom_e("uacute",250);
			101: e = rom_e("ucirc",251); 102: e = rom_e("uuml",252);
			103: e = rom_e("yacute",253); 104: e = rom_e("thorn",254);
			105: e = rom_e("yuml",255); 106: e = rom_e("forall",8704);
			107: e = rom_e("part",8706); 108: e = rom_e("exist",8707);
			109: e = rom_e("empty",8709); 110: e = rom_e("nabla",8711);
			111: e = rom_e("isin",8712); 112: e = rom_e("notin",8713);
			113: e = rom_e("ni",8715); 114: e = rom_e("prod",8719);
			115: e = rom_e("sum",8721); 116: e = rom_e("minus",8722);
			117: e = rom_e("lowast",8727); 118: e = rom_e("radic",8730);
			119: e = rom_e("prop",8733); 120: e = rom_e("infin",8734);
			121: e = rom_e("ang",8736); 122: e = rom_e("and",8743);
			123: e = rom_e("or",8744); 124: e = rom_e("cap",8745);
			125: e = rom_e("cup",8746); 126: e = rom_e("int",8747);
			127: e = rom_e("there4",8756); 128: e = rom_e("sim",8764);
			129: e = rom_e("cong",8773); 130: e = rom_e("asymp",8776);
			131: e = rom_e("ne",8800); 132: e = rom_e("equiv",8801);
			133: e = rom_e("le",8804); 134: e = rom_e("ge",8805);
			135: e = rom_e("sub",8834); 136: e = rom_e("sup",8835);
			137: e = rom_e("nsub",8836); 138: e = rom_e("sube",8838);
			139: e = rom_e("supe",8839); 140: e = rom_e("oplus",8853);
			141: e = rom_e("otimes",8855); 142: e = rom_e("perp",8869);
			143: e = rom_e("sdot",8901); 144: e = rom_e("Alpha",913);
			145: e = rom_e("Beta",914); 146: e = rom_e("Gamma",915);
			147: e = rom_e("Delta",916); 148: e = rom_e("Epsilon",917);
			149: e = rom_e("Zeta",918); 150: e = rom_e("Eta",919);
			151: e = rom_e("Theta",920); 152: e = rom_e("Iota",921);
			153: e = rom_e("Kappa",922); 154: e = rom_e("Lambda",923);
			155: e = rom_e("Mu",924); 156: e = rom_e("Nu",925);
			157: e = rom_e("Xi",926); 158: e = rom_e("Omicron",927);
			159: e = rom_e("Pi",928); 160: e = rom_e("Rho",929);
			161: e = rom_e("Sigma",931); 162: e = rom_e("Tau",932);
			163: e = rom_e("Upsilon",933); 164: e = rom_e("Phi",934);
			165: e = rom_e("Chi",935); 166: e = rom_e("Psi",936);
			167: e = rom_e("Omega",937); 168: e = rom_e("alpha",945);
			169: e = rom_e("beta",946); 170: e = rom_e("gamma",947);
			171: e = rom_e("delta",948); 172: e = rom_e("epsilon",949);
			173: e = rom_e("zeta",950); 174: e = rom_e("eta",951);
			175: e = rom_e("theta",952); 176: e = rom_e("iota",953);
			177: e = rom_e("kappa",954); 178: e = rom_e("lambda",955);
			179: e = rom_e("mu",956); 180: e = rom_e("nu",957);
			181: e = rom_e("xi",958); 182: e = rom_e("omicron",959);
			183: e = rom_e("pi",960); 184: e = rom_e("rho",961);
			185: e = rom_e("sigmaf",962); 186: e = rom_e("sigma",963);
			187: e = rom_e("tau",964); 188: e = rom_e("upsilon",965);
			189: e = rom_e("phi",966); 190: e = rom_e("chi",967);
			191: e = rom_e("psi",968); 192: e = rom_e("omega",969);
			193: e = rom_e("thetasym",977); 194: e = rom_e("upsih",978);
			195: e = rom_e("piv",982); 196: e = rom_e("OElig",338);
			197: e = rom_e("oelig",339); 198: e = rom_e("Scaron",352);
			199: e = rom_e("scaron",353); 200: e = rom_e("Yuml",376);
			201: e = rom_e("fnof",402); 202: e = rom_e("circ",710);
			203: e = rom_e("tilde",732); 204: e = rom_e("ensp",8194);
			205: e = rom_e("emsp",8195); 206: e = rom_e("thinsp",8201);
			207: e = rom_e("zwnj",8204); 208: e = rom_e("zwj",8205);
			209: e = rom_e("lrm",8206); 210: e = rom_e("rlm",8207);
			211: e = rom_e("ndash",8211); 212: e = rom_e("mdash",8212);
			213: e = rom_e("lsquo",8216); 214: e = rom_e("rsquo",8217);
			215: e = rom_e("sbquo",8218); 216: e = rom_e("ldquo",8220);
			217: e = rom_e("rdquo",8221); 218: e = rom_e("bdquo",8222);
			219: e = rom_e("dagger",8224); 220: e = rom_e("Dagger",8225);
			221: e = rom_e("bull",8226); 222: e = rom_e("hellip",8230);
			223: e = rom_e("permil",8240); 224: e = rom_e("prime",8242);
			225: e = rom_e("Prime",8243); 226: e = rom_e("lsaquo",8249);
			227: e = rom_e("rsaquo",8250); 228: e = rom_e("oline",8254);
			229: e = rom_e("euro",8364); 230: e = rom_e("trade",8482);
			231: e = rom_e("larr",8592); 232: e = rom_e("uarr",8593);
			233: e = rom_e("rarr",8594); 234: e = rom_e("darr",8595);
			235: e = rom_e("harr",8596); 236: e = rom_e("crarr",8629);
			237: e = rom_e("lceil",8968); 238: e = rom_e("rceil",8969);
			239: e = rom_e("lfloor",8970); 240: e = rom_e("rfloor",8971);
			241: e = rom_e("loz",9674); 242: e = rom_e("spades",9824);
			243: e = rom_e("clubs",9827); 244: e = rom_e("hearts",9829);
			245: e = rom_e("diams",9830);
			default: e = '0;
		endcase
		return e;
	endfunction
endpackage
`default_nettype wire

FILE: rtl/hcrd_stream_if.sv
// Valid/ready stream interface, payload type set by parameter.
// No dependencies.
`default_nettype none
interface hcrd_stream_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/hcrd_datapath.sv
// Datapath: digit accumulator, name store, ROM search and UTF-8 encoder.
// Depends on hcrd_pkg.
`default_nettype none
module hcrd_datapath #(
	parameter int NAME_CHARS = 8
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic [7:0]        ch,
	input  wire hcrd_pkg::dp_cmd_t cmd,
	output hcrd_pkg::dp_sts_t      sts,
	output hcrd_pkg::out_item_t    res
);
	import hcrd_pkg::*;
	localparam int PW = $clog2(NAME_CHARS + 1);
	localparam int IW = $clog2(NAME_CHARS);

	phase_t              phase_q;
	logic [PW-1:0]       pos_q;      // name length
	logic [3:0]          ndig_q;     // digits seen, saturating
	logic [20:0]         acc_q;
	logic                bad_q;
	logic [7:0]          name_q [NAME_CHARS];
	logic [ROM_AW-1:0]   ridx_q;
	rom_entry_t          rent_q;     // registered ROM read
	logic [20:0]         cp_q;
	logic                good_q;

	logic        is_dec, is_hex;
	logic [3:0]  dval;
	logic [25:0] nxt;
	logic        base16;
	logic        hit;
	logic [20:0] cp_sel;

	assign base16 = (phase_q == PH_HEX);
	always_comb begin
		is_dec = (ch >= 8'h30) && (ch <= 8'h39);
		is_hex = 1'b0;
		dval = ch[3:0];
		if (base16 && ((ch >= 8'h61 && ch <= 8'h66) || (ch >= 8'h41 && ch <= 8'h46))) begin
			is_hex = 1'b1;
			dval = 4'(ch[3:0] + 4'd9);
		end
		// shift-and-add, no multiplier needed
		if (base16)
			nxt = {1'b0, acc_q, 4'b0} + 26'(dval);
		else
			nxt = {2'b0, acc_q, 3'b0} + {4'b0, acc_q, 1'b0} + 26'(dval);
	end

	always_comb begin
		hit = (rent_q.len == 4'(pos_q)) && (rent_q.len != 4'd0);
		for (int k = 0; k < ROM_NAME_MAX; k++)
			if (k < int'(rent_q.len) && k < NAME_CHARS)
				if (rent_q.nm[k*8 +: 8] != name_q[k]) hit = 1'b0;
		if (int'(rent_q.len) > NAME_CHARS) hit = 1'b0;
	end

	// rent_q holds entry ridx_q-1 while the search runs
	always_ff @(posedge clk) begin
		if (cmd.step && phase_q == PH_NAME && 32'(pos_q) < NAME_CHARS)
			name_q[IW'(pos_q)] <= ch;
		else if (cmd.step && phase_q == PH_FIRST && ch != CH_HASH)
			name_q[0] <= ch;
		if (cmd.rom_start || cmd.rom_next)
			rent_q <= name_rom(cmd.rom_start ? '0 : ridx_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_LEAD;
			pos_q <= '0;
			ndig_q <= '0;
			acc_q <= '0;
			bad_q <= 1'b0;
			ridx_q <= '0;
			cp_q <= '0;
			good_q <= 1'b0;
		end else begin
			if (cmd.rom_start) ridx_q <= ROM_AW'(1);
			else if (cmd.rom_next) ridx_q <= ridx_q + ROM_AW'(1);
			if (cmd.load_out) begin
				good_q <= cmd.good;
				cp_q <= cmd.good ? cp_sel : '0;
			end
			if (cmd.clear) begin
				phase_q <= PH_LEAD;
				pos_q <= '0;
				ndig_q <= '0;
				acc_q <= '0;
				bad_q <= 1'b0;
			end else if (cmd.step) begin
				unique case (phase_q)
					PH_LEAD: phase_q <= PH_FIRST;
					PH_FIRST: begin
						if (ch == CH_HASH) phase_q <= PH_HASH;
						else begin
							phase_q <= PH_NAME;
							pos_q <= PW'(1);
						end
					end
					PH_HASH, PH_DEC, PH_HEX: begin
						if (phase_q == PH_HASH && (ch == CH_LX || ch == CH_UX))
							phase_q <= PH_HEX;
						else begin
							if (phase_q == PH_HASH) phase_q <= PH_DEC;
							if (!(is_dec || is_hex)) bad_q <= 1'b1;
							else begin
								if (nxt > 26'(CP_MAX)) begin
									bad_q <= 1'b1;
									acc_q <= CP_MAX;
								end else acc_q <= nxt[20:0];
								if (ndig_q != 4'd15) ndig_q <= ndig_q + 4'd1;
							end
						end
					end
					PH_NAME: begin
						if (32'(pos_q) < NAME_CHARS) pos_q <= pos_q + PW'(1);
						else bad_q <= 1'b1;
					end
					default: phase_q <= PH_LEAD;
				endcase
			end
		end
	end

	assign cp_sel = (phase_q == PH_NAME) ? rent_q.cp : acc_q;

	assign sts.phase = phase_q;
	assign sts.num_good = !bad_q && ndig_q != 4'd0 && acc_q > 21'd1;
	assign sts.name_ok = !bad_q && pos_q != '0 && 32'(pos_q) <= ROM_NAME_MAX;
	assign sts.hit = hit;
	assign sts.rom_last = (ridx_q == ROM_AW'(ROM_COUNT));
	assign sts.nbytes = (cp_q < 21'h80) ? 3'd1 : (cp_q < 21'h800) ? 3'd2 :
		(cp_q < 21'h10000) ? 3'd3 : 3'd4;

	always_comb begin
		res.code_point = cp_q;
		res.ok = good_q;
		res.end_of_run = !good_q || (3'(cmd.byte_idx) + 3'd1 == sts.nbytes);
		res.utf8_byte = '0;
		if (good_q) begin
			unique case (sts.nbytes)
				3'd1: res.utf8_byte = cp_q[7:0];
				3'd2: res.utf8_byte = (cmd.byte_idx == 2'd0) ? {3'b110, cp_q[10:6]} :
					{2'b10, cp_q[5:0]};
				3'd3: begin
					case (cmd.byte_idx)
						2'd0: res.utf8_byte = {4'b1110, cp_q[15:12]};
						2'd1: res.utf8_byte = {2'b10, cp_q[11:6]};
						default: res.utf8_byte = {2'b10, cp_q[5:0]};
					endcase
				end
				default: begin
					case (cmd.byte_idx)
						2'd0: res.utf8_byte = {5'b11110, cp_q[20:18]};
						2'd1: res.utf8_byte = {2'b10, cp_q[17:12]};
						2'd2: res.utf8_byte = {2'b10, cp_q[11:6]};
						default: res.utf8_byte = {2'b10, cp_q[5:0]};
					endcase
				end
			endcase
		end
	end
endmodule
`default_nettype wire

FILE: rtl/hcrd_ctrl.sv
// Controller: sequences byte intake, ROM search and result emission.
// Depends on hcrd_pkg and the macros header.
`default_nettype none
`include "html_char_reference_decoder_unit_macros.svh"
module hcrd_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire logic              in_final,
	output logic                   in_ready,
	output logic                   out_valid,
	input  wire logic              out_ready,
	input  wire hcrd_pkg::dp_sts_t sts,
	output hcrd_pkg::dp_cmd_t      cmd
);
	import hcrd_pkg::*;
	typedef enum logic [2:0] {S_IDLE, S_ROMRD, S_SEARCH, S_LOAD, S_EMIT} state_t;
	state_t     state_q;
	logic [1:0] idx_q;
	logic       acc_in, found;
	logic       last_byte;

	assign in_ready = (state_q == S_IDLE);
	assign out_valid = (state_q == S_EMIT);
	assign acc_in = in_valid && in_ready;
	// a failure loads cp 0, which encodes as a single byte
	assign last_byte = (3'(idx_q) + 3'd1 == sts.nbytes);

	always_comb begin
		cmd = '0;
		cmd.byte_idx = idx_q;
		cmd.step = acc_in && !in_final;
		cmd.rom_start = acc_in && in_final;
		cmd.rom_next = (state_q == S_SEARCH);
		// verdict: numeric checks directly, names by search
		if (state_q == S_LOAD) begin
			cmd.load_out = 1'b1;
			cmd.clear = 1'b1;
			if (sts.phase == PH_DEC || sts.phase == PH_HEX) cmd.good = sts.num_good;
			else if (sts.phase == PH_NAME) cmd.good = sts.name_ok && found;
			else cmd.good = 1'b0;
		end
		if (state_q == S_SEARCH && sts.hit) begin
			cmd.load_out = 1'b1;
			cmd.clear = 1'b1;
			cmd.good = sts.name_ok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q <= '0;
			found <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: if (acc_in && in_final) begin
					found <= 1'b0;
					state_q <= (sts.phase == PH_NAME && sts.name_ok) ? S_ROMRD : S_LOAD;
				end
				S_ROMRD: state_q <= S_SEARCH;
				S_SEARCH: begin
					if (sts.hit) begin
						idx_q <= '0;
						state_q <= S_EMIT;
					end else if (sts.rom_last) state_q <= S_LOAD;
				end
				S_LOAD: begin
					idx_q <= '0;
					state_q <= S_EMIT;
				end
				S_EMIT: if (out_ready) begin
					idx_q <= idx_q + 2'd1;
					if (last_byte) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`HCRD_ASSERT_IMP(a_no_in_when_busy, clk, arst_n, state_q != S_IDLE, !in_ready)
	`HCRD_ASSERT_NEXT(a_load_to_emit, clk, arst_n, state_q == S_LOAD, state_q == S_EMIT)
	`HCRD_ASSERT_IMP(a_idx_range, clk, arst_n, out_valid, 3'(idx_q) < 3'd4)
endmodule
`default_nettype wire

FILE: rtl/html_char_reference_decoder_unit.sv
// HTML character reference decoder: takes one entity a byte per cycle;
// on the terminating byte emits 1 to 4 UTF-8 result items or one failure.
// Body bytes are accepted while idle. A numeric terminator passes through the
// load state to emission; a name terminator first runs a sequential search of
// the name ROM, one entry a cycle, ending at a hit or the last entry; result
// bytes are then emitted one per accepted handshake on the output channel.
`default_nettype none
`include "html_char_reference_decoder_unit_macros.svh"
module html_char_reference_decoder_unit #(
	parameter int NAME_CHARS = 8
) (
	input wire logic clk,
	input wire logic arst_n,
	hcrd_stream_if.sink   in_ch,
	hcrd_stream_if.source out_ch
);
	import hcrd_pkg::*;
	dp_cmd_t   cmd;
	dp_sts_t   sts;
	out_item_t res;
	logic      last;

	hcrd_datapath #(.NAME_CHARS(NAME_CHARS)) u_dp (
		.clk(clk), .arst_n(arst_n), .ch(in_ch.data.ch), .cmd(cmd), .sts(sts), .res(res)
	);
	hcrd_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_ch.valid),
		.in_final(in_ch.data.final_req), .in_ready(in_ch.ready),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready), .sts(sts), .cmd(cmd)
	);
	assign out_ch.data = res;
	assign last = res.end_of_run;

	`HCRD_ASSERT_IMP(a_fail_single, clk, arst_n, out_ch.valid && !res.ok, last)
	`HCRD_ASSERT_IMP(a_fail_zero, clk, arst_n, out_ch.valid && !res.ok, res.code_point == 21'd0)
	`HCRD_ASSERT_IMP(a_no_overlap, clk, arst_n, out_ch.valid, !in_ch.ready)
endmodule
`default_nettype wire

FILE: tb/tb_top.sv
// Testbench for the character reference decoder: random and directed entities,
// checked result by result against a predictor kept in a scoreboard class.
// Depends on hcrd_pkg, hcrd_stream_if and html_char_reference_decoder_unit.
`timescale 1ns / 1ps
module tb_top;
	import hcrd_pkg::*;

	localparam int NCH = 8;
	localparam int WDOG_LIMIT = 20000;

	class entity_scoreboard;
		phase_t      ph;
		int unsigned pos;
		int unsigned acc;
		bit          bad;
		byte unsigned name_buf[NCH];
		out_item_t   pending[$];
		int          mismatches;
		int          results_seen;

		function void clear_entity();
			ph = PH_LEAD;
			pos = 0;
			acc = 0;
			bad = 0;
		endfunction

		function void feed_digit(byte unsigned c, int unsigned base);
			int unsigned d;
			if (c >= "0" && c <= "9") d = c - "0";
			else if (base == 16 && c >= "a" && c <= "f") d = c - "a" + 10;
			else if (base == 16 && c >= "A" && c <= "F") d = c - "A" + 10;
			else begin
				bad = 1;
				return;
			end
			acc = acc * base + d;
			if (acc > CP_MAX) begin
				bad = 1;
				acc = CP_MAX;
			end
			if (pos < 15) pos++;
		endfunction

		function bit find_name(output int unsigned cp);
			rom_entry_t e;
			bit same;
			cp = 0;
			for (int i = 0; i < 256; i++) begin
				e = name_entry(i);
				if (e.len == 0 || e.len != pos) continue;
				same = 1;
				for (int j = 0; j < e.len; j++)
					if (e.nm[j*8 +: 8] != name_buf[j]) same = 0;
				if (same) begin
					cp = e.cp;
					return 1;
				end
			end
			return 0;
		endfunction

		// independent copy of the name table, indexed like the ROM
		function rom_entry_t name_entry(int i);
			rom_entry_t e;
			string names[$] = '{"quot","QUOT","apos","APOS","amp","AMP","lt","LT","gt",
				"GT","nbsp","iexcl","cent","pound","curren","yen","brvbar","sect","uml",
				"copy","ordf","laquo","not","shy","reg","macr","deg","plusmn","sup2",
				"sup3","acute","micro","para","middot","cedil","sup1","ordm","raquo",
				"frac14","frac12","frac34","iquest","times","divide","Agrave","Aacute",
				"Acirc","Atilde","Auml","Aring","AElig","Ccedil","Egrave","Eacute",
				"Ecirc","Euml","Igrave","Iacute","Icirc","Iuml","ETH","Ntilde","Ograve",
				"Oacute","Ocirc","Otilde","Ouml","Oslash","Ugrave","Uacute","Ucirc",
				"Uuml","Yacute","THORN","szlig","agrave","aacute","acirc","atilde",
				"auml","aring","aelig","ccedil","egrave","eacute","ecirc","euml",
				"igrave","iacute","icirc","iuml","eth","ntilde","ograve","oacute",
				"ocirc","otilde","ouml","oslash","ugrave","uacute","ucirc","uuml",
				"yacute","thorn","yuml","forall","part","exist","empty","nabla","isin",
				"notin","ni","prod","sum","minus","lowast","radic","prop","infin","ang",
				"and","or","cap","cup","int","there4","sim","cong","asymp","ne","equiv",
				"le","ge","sub","sup","nsub","sube","supe","oplus","otimes","perp",
				"sdot","Alpha","Beta","Gamma","Delta","Epsilon","Zeta","Eta","Theta",
				"Iota","Kappa","Lambda","Mu","Nu","Xi","Omicron","Pi","Rho","Sigma",
				"Tau","Upsilon","Phi","Chi","Psi","Omega","alpha","beta","gamma",
				"delta","epsilon","zeta","eta","theta","iota","kappa","lambda","mu",
				"nu","xi","omicron","pi","rho","sigmaf","sigma","tau","upsilon","phi",
				"chi","psi","omega","thetasym","upsih","piv","OElig","oelig","Scaron",
				"scaron","Yuml","fnof","circ","tilde","ensp","emsp","thinsp","zwnj",
				"zwj","lrm","rlm","ndash","mdash","lsquo","rsquo","sbquo","ldquo",
				"rdquo","bdquo","dagger","Dagger","bull","hellip","permil","prime",
				"Prime","lsaquo","rsaquo","oline","euro","trade","larr","uarr","rarr",
				"darr","harr","crarr","lceil","rceil","lfloor","rfloor","loz","spades",
				"clubs","hearts","diams"};
			int cps[$] = '{34,34,39,39,38,38,60,60,62,62,160,161,162,163,164,165,166,
				167,168,169,170,171,172,173,174,175,176,177,178,179,180,181,182,183,
				184,185,186,187,188,189,190,191,215,247,192,193,194,195,196,197,198,
				199,200,201,202,203,204,205,206,207,208,209,210,211,212,213,214,216,
				217,218,219,220,221,222,223,224,225,226,227,228,229,230,231,232,233,
				234,235,236,237,238,239,240,241,242,243,244,245,246,248,249,250,251,
				252,253,254,255,8704,8706,8707,8709,8711,8712,8713,8715,8719,8721,
				8722,8727,8730,8733,8734,8736,8743,8744,8745,8746,8747,8756,8764,8773,
				8776,8800,8801,8804,8805,8834,8835,8836,8838,8839,8853,8855,8869,8901,
				913,914,915,916,917,918,919,920,921,922,923,924,925,926,927,928,929,
				931,932,933,934,935,936,937,945,946,947,948,949,950,951,952,953,954,
				955,956,957,958,959,960,961,962,963,964,965,966,967,968,969,977,978,
				982,338,339,352,353,376,402,710,732,8194,8195,8201,8204,8205,8206,
				8207,8211,8212,8216,8217,8218,8220,8221,8222,8224,8225,8226,8230,8240,
				8242,8243,8249,8250,8254,8364,8482,8592,8593,8594,8595,8596,8629,8968,
				8969,8970,8971,9674,9824,9827,9829,9830};
			e = '0;
			if (i < names.size()) begin
				e.len = 4'(names[i].len());
				for (int k = 0; k < names[i].len(); k++) e.nm[k*8 +: 8] = names[i][k];
				e.cp = 21'(cps[i]);
			end
			return e;
		endfunction

		function void push_utf8(int unsigned cp);
			byte unsigned b[4];
			int n;
			out_item_t r;
			if (cp < 'h80) begin
				b[0] = 8'(cp); n = 1;
			end else if (cp < 'h800) begin
				b[0] = 8'('hC0 | (cp >> 6)); b[1] = 8'('h80 | (cp & 'h3F)); n = 2;
			end else if (cp < 'h10000) begin
				b[0] = 8'('hE0 | (cp >> 12)); b[1] = 8'('h80 | ((cp >> 6) & 'h3F));
				b[2] = 8'('h80 | (cp & 'h3F)); n = 3;
			end else begin
				b[0] = 8'('hF0 | ((cp >> 18) & 7));
				b[1] = 8'('h80 | ((cp >> 12) & 'h3F));
				b[2] = 8'('h80 | ((cp >> 6) & 'h3F)); b[3] = 8'('h80 | (cp & 'h3F)); n = 4;
			end
			for (int k = 0; k < n; k++) begin
				r.utf8_byte = b[k];
				r.code_point = 21'(cp);
				r.ok = 1;
				r.end_of_run = (k == n - 1);
				pending.push_back(r);
			end
		endfunction

		function void note_request(in_item_t it);
			int unsigned cp;
			bit good;
			out_item_t r;
			if (it.final_req) begin
				good = 0;
				cp = 0;
				if (ph == PH_DEC || ph == PH_HEX) begin
					good = !bad && pos > 0 && acc > 1;
					cp = acc;
				end else if (ph == PH_NAME)
					good = !bad && pos > 0 && find_name(cp);
				if (good) push_utf8(cp);
				else begin
					r = '0;
					r.end_of_run = 1;
					pending.push_back(r);
				end
				clear_entity();
				return;
			end
			case (ph)
				PH_FIRST:
					if (it.ch == CH_HASH) ph = PH_HASH;
					else begin
						ph = PH_NAME;
						name_buf[0] = it.ch;
						pos = 1;
					end
				PH_HASH:
					if (it.ch == CH_LX || it.ch == CH_UX) ph = PH_HEX;
					else begin
						ph = PH_DEC;
						feed_digit(it.ch, 10);
					end
				PH_DEC: feed_digit(it.ch, 10);
				PH_HEX: feed_digit(it.ch, 16);
				PH_NAME:
					if (pos < NCH) begin
						name_buf[pos] = it.ch;
						pos++;
					end else bad = 1;
				default: begin
					clear_entity();
					ph = PH_FIRST;
				end
			endcase
		endfunction

		function void check_result(out_item_t got);
			out_item_t want;
			results_seen++;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %p", got);
				return;
			end
			want = pending.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10)
					$display({"mismatch: expected byte=%h cp=%h ok=%b end=%b, ",
						"got byte=%h cp=%h ok=%b end=%b"},
						want.utf8_byte, want.code_point, want.ok, want.end_of_run,
						got.utf8_byte, got.code_point, got.ok, got.end_of_run);
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	hcrd_stream_if #(.T(in_item_t)) in_ch ();
	hcrd_stream_if #(.T(out_item_t)) out_ch ();

	html_char_reference_decoder_unit #(.NAME_CHARS(NCH)) uut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source)
	);

	always begin
		#10 clk = 1;
		#10 clk = 0;
	end

	entity_scoreboard board = new();
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int requests = 0;
	int entities = 0;
	int quiet_cycles = 0;

	initial begin
		in_ch.valid = 0;
		in_ch.data = '0;
		out_ch.ready = 0;
		board.clear_entity();
	end

	always @(posedge clk) begin
		if (arst_n) begin
			out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
			if (out_ch.valid && out_ch.ready) board.check_result(out_ch.data);
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WDOG_LIMIT) begin
				$display("watchdog: no traffic for %0d cycles", WDOG_LIMIT);
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	// one request; idle cycles are inserted before it at random
	task automatic send_byte(byte unsigned c, bit fin);
		in_item_t it;
		while ($urandom_range(99) < send_idle_pct) begin
			in_ch.valid <= 0;
			@(posedge clk);
		end
		it.ch = c;
		it.final_req = fin;
		in_ch.valid <= 1;
		in_ch.data <= it;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		board.note_request(it);
		requests++;
	endtask

	task automatic send_entity(string body, byte unsigned lead = "&",
			byte unsigned term = ";");
		send_byte(lead, 0);
		for (int k = 0; k < body.len(); k++) send_byte(body[k], 0);
		send_byte(term, 1);
		entities++;
	endtask

	task automatic drain();
		in_ch.valid <= 0;
		while (board.pending.size() != 0) @(posedge clk);
	endtask

	function automatic string rand_digits(int n, bit hex);
		string s = "";
		string d = hex ? "0123456789abcdefABCDEF" : "0123456789";
		for (int k = 0; k < n; k++) s = {s, string'(d[$urandom_range(d.len() - 1)])};
		return s;
	endfunction

	task automatic random_entity();
		int kind = $urandom_range(99);
		rom_entry_t e;
		string s;
		int n;
		if (kind < 25) begin
			s = $sformatf("#%0d", $urandom_range(2, 'h10FFFF));
			if ($urandom_range(3) == 0) s = {"#", rand_digits($urandom_range(1, 9), 0)};
		end else if (kind < 50) begin
			s = $sformatf($urandom_range(1) ? "#x%0h" : "#X%0H",
				$urandom_range(3) == 0 ? $urandom_range(2, 'h7F) : $urandom_range(2, 'h10FFFF));
			if ($urandom_range(3) == 0) s = {"#x", rand_digits($urandom_range(1, 8), 1)};
		end else if (kind < 80) begin
			e = board.name_entry($urandom_range(245));
			s = "";
			for (int k = 0; k < e.len; k++) s = {s, string'(byte'(e.nm[k*8 +: 8]))};
			if ($urandom_range(5) == 0) s[$urandom_range(s.len() - 1)] = $urandom_range(255);
		end else begin
			// noise: arbitrary bytes of random length, any lead and terminator
			s = "";
			n = $urandom_range(0, 11);
			for (int k = 0; k < n; k++) s = {s, string'(byte'($urandom_range(1, 255)))};
			if (n > 0 && $urandom_range(1)) s[0] = "#";
			send_entity(s, $urandom_range(255), $urandom_range(255));
			return;
		end
		send_entity(s);
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: lead and terminator values, early terminators, edge values
		send_entity("amp", 8'h00, 8'hFF);
		send_entity("lt", 8'hFF, 8'h00);
		send_entity("", "&", ";");
		send_entity("#");
		send_entity("#x");
		send_entity("#X");
		send_entity("#0");
		send_entity("#1");
		send_entity("#2");
		send_entity("#x7F");
		send_entity("#x80");
		send_entity("#x7ff");
		send_entity("#X800");
		send_entity("#xFFFF");
		send_entity("#xD800");
		send_entity("#x10000");
		send_entity("#x10FFFF");
		send_entity("#x110000");
		send_entity("#99999999");
		send_entity("# 65");
		send_entity("#-65");
		send_entity("#0x41");
		send_entity("thetasym");
		send_entity("thetasymx");
		send_entity("bogus");
		send_byte("&", 1);
		drain();

		// hold off until every expected result is back, then run the phases
		for (int phs = 0; phs < 4; phs++) begin
			send_idle_pct = (phs == 1 || phs == 3) ? 78 : 0;
			recv_stall_pct = (phs == 2 || phs == 3) ? 78 : 0;
			if (phs == 3) begin
				send_idle_pct = 6;
				recv_stall_pct = 6;
			end
			for (int k = 0; k < 7; k++) random_entity();
			drain();
		end
		recv_stall_pct = 0;
		repeat (300) @(posedge clk);
		$display("covered %0d requests in %0d entities, %0d results checked",
			requests, entities, board.results_seen);
		if (board.mismatches == 0 && board.pending.size() == 0)
			$display("DONE: 0 errors");
		else begin
			$display("%0d mismatches, %0d results outstanding", board.mismatches,
				board.pending.size());
			$display("DONE: errors detected");
		end
		$finish;
	end
endmodule
